FILE: design/h3hv_pkg.sv
// Shared types, keyword tables and reason codes for the HTTP/3 header validator.
// No dependencies; imported by every module of the block.
package h3hv_pkg;

    // Reject reasons
    localparam logic [2:0] RSN_OK      = 3'd0;
    localparam logic [2:0] RSN_EMPTY   = 3'd1;
    localparam logic [2:0] RSN_UPPER   = 3'd2;
    localparam logic [2:0] RSN_PSEUDO  = 3'd3;
    localparam logic [2:0] RSN_FORBID  = 3'd4;
    localparam logic [2:0] RSN_MISSING = 3'd5;
    localparam logic [2:0] RSN_STATUS  = 3'd6;
    localparam logic [2:0] RSN_SWITCH  = 3'd7;

    localparam logic MODE_REQUEST  = 1'b0;
    localparam logic MODE_RESPONSE = 1'b1;

    // Name keyword indexes; the colon bit marks a leading ':'
    localparam int NAME_WORDS  = 11;
    localparam int KW_METHOD   = 0;
    localparam int KW_SCHEME   = 1;
    localparam int KW_PATH     = 2;
    localparam int KW_AUTH     = 3;
    localparam int KW_STATUS   = 4;
    localparam int KW_TE       = 5;
    localparam int KW_CONN     = 6;
    localparam int KW_UPGRADE  = 10;
    localparam int KW_COLON    = 11;
    localparam int NAME_CAND_W = NAME_WORDS + 1;

    localparam int VALUE_WORDS = 2;
    localparam int VW_CONNECT  = 0;
    localparam int VW_TRAILERS = 1;

    localparam int NAME_TEXT_W  = 17 * 8;
    localparam int VALUE_TEXT_W = 8 * 8;

    localparam logic [NAME_TEXT_W-1:0] NAME_TEXT [NAME_WORDS] = '{
        ":method", ":scheme", ":path", ":authority", ":status", "te",
        "connection", "keep-alive", "proxy-connection", "transfer-encoding",
        "upgrade"
    };
    localparam logic [4:0] NAME_SIZE [NAME_WORDS] = '{
        5'd7, 5'd7, 5'd5, 5'd10, 5'd7, 5'd2, 5'd10, 5'd10, 5'd16, 5'd17, 5'd7
    };
    localparam logic [VALUE_TEXT_W-1:0] VALUE_TEXT [VALUE_WORDS] = '{
        "CONNECT", "trailers"
    };
    localparam logic [3:0] VALUE_SIZE [VALUE_WORDS] = '{4'd7, 4'd8};

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [9:0] STATUS_SWITCHING = 10'd101;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       in_value;
        logic       byte_present;
        logic       part_end;
        logic       message_end;
    } item_t;

    typedef struct packed {
        logic [4:0]             name_pos;
        logic [NAME_CAND_W-1:0] name_cand;
        logic                   name_upper;
        logic [3:0]             value_pos;
        logic [VALUE_WORDS-1:0] value_cand;
        logic [9:0]             digits;
        logic                   bad_digit;
        logic                   pending;
    } part_t;

    localparam part_t PART_RESET = '{
        name_pos:   '0,
        name_cand:  '1,
        name_upper: 1'b0,
        value_pos:  '0,
        value_cand: '1,
        digits:     '0,
        bad_digit:  1'b0,
        pending:    1'b0
    };

    typedef struct packed {
        logic       block_valid;
        logic [2:0] reject_reason;
        logic [9:0] status_value;
    } result_t;

    // Character at position pos of name keyword k (caller checks pos < length)
    function automatic logic [7:0] name_char(input int k, input logic [4:0] pos);
        int sh;
        sh = (int'(NAME_SIZE[k]) - 1 - int'(pos)) * 8;
        if (sh < 0) begin
            sh = 0;
        end
        return NAME_TEXT[k][sh +: 8];
    endfunction

    function automatic logic [7:0] value_char(input int k, input logic [3:0] pos);
        int sh;
        sh = (int'(VALUE_SIZE[k]) - 1 - int'(pos)) * 8;
        if (sh < 0) begin
            sh = 0;
        end
        return VALUE_TEXT[k][sh +: 8];
    endfunction

    function automatic logic name_is(input part_t p, input int k);
        return p.name_cand[k] && (p.name_pos == NAME_SIZE[k]);
    endfunction

    function automatic logic value_is(input part_t p, input int k);
        return p.value_cand[k] && (p.value_pos == VALUE_SIZE[k]);
    endfunction

endpackage

FILE: design/h3hv_part_match.sv
// Per-header match state: keyword candidates, positions and status digits.
// Depends on h3hv_pkg. Presents the state with the current byte folded in.
module h3hv_part_match
    import h3hv_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  step_en,
    input  item_t item,
    input  logic  part_clear,
    output part_t part_now
);

    part_t part_reg;
    part_t part_next;

    always_comb begin
        part_now = part_reg;
        if (item.byte_present) begin
            if (item.in_value) begin
                for (int k = 0; k < VALUE_WORDS; k++) begin
                    if (!(part_reg.value_pos < VALUE_SIZE[k]) ||
                        item.data_byte != value_char(k, part_reg.value_pos)) begin
                        part_now.value_cand[k] = 1'b0;
                    end
                end
                if (part_reg.value_pos < 4'd3) begin
                    if (item.data_byte inside {[8'h30:8'h39]}) begin
                        part_now.digits = 10'(part_reg.digits * 10'd10
                                              + {2'b00, item.data_byte - CH_ZERO});
                    end else begin
                        part_now.bad_digit = 1'b1;
                    end
                end
                if (part_reg.value_pos != 4'd15) begin
                    part_now.value_pos = part_reg.value_pos + 4'd1;
                end
            end else begin
                for (int k = 0; k < NAME_WORDS; k++) begin
                    if (!(part_reg.name_pos < NAME_SIZE[k]) ||
                        item.data_byte != name_char(k, part_reg.name_pos)) begin
                        part_now.name_cand[k] = 1'b0;
                    end
                end
                if (part_reg.name_pos == 5'd0 && item.data_byte != CH_COLON) begin
                    part_now.name_cand[KW_COLON] = 1'b0;
                end
                if (item.data_byte inside {[8'h41:8'h5A]}) begin
                    part_now.name_upper = 1'b1;
                end
                if (part_reg.name_pos != 5'd31) begin
                    part_now.name_pos = part_reg.name_pos + 5'd1;
                end
            end
        end
        if (item.byte_present || item.part_end) begin
            part_now.pending = 1'b1;
        end
        part_next = part_clear ? PART_RESET : part_now;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            part_reg <= PART_RESET;
        end else if (step_en) begin
            part_reg <= part_next;
        end
    end

endmodule

FILE: design/h3hv_rules.sv
// Header and block rules: pseudo-header tracking, sticky first error, verdict.
// Depends on h3hv_pkg; consumes the per-header match state from h3hv_part_match.
module h3hv_rules
    import h3hv_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    step_en,
    input  item_t   item,
    input  part_t   part_now,
    input  logic    check_mode,
    output logic    part_clear,
    output logic    result_valid,
    output result_t result
);

    logic [2:0] first_error_reg, first_error_next;
    logic [4:0] pseudo_seen_reg, pseudo_seen_next;
    logic       pseudo_closed_reg, pseudo_closed_next;
    logic       connect_reg, connect_next;
    logic [9:0] status_reg, status_next;
    logic       any_header_reg, any_header_next;

    logic [2:0] fe_w;
    logic [4:0] seen_w;
    logic       closed_w, connect_w, any_w;
    logic [9:0] status_w;
    logic [2:0] chk;
    logic [2:0] reason;
    logic [3:0] rq_hit;
    logic       finish;
    logic       is_pseudo;
    logic       forbidden;

    always_comb begin
        fe_w      = first_error_reg;
        seen_w    = pseudo_seen_reg;
        closed_w  = pseudo_closed_reg;
        connect_w = connect_reg;
        status_w  = status_reg;
        any_w     = any_header_reg;
        chk       = RSN_OK;
        forbidden = 1'b0;

        for (int k = 0; k < 4; k++) begin
            rq_hit[k] = name_is(part_now, k);
        end
        for (int k = KW_CONN; k <= KW_UPGRADE; k++) begin
            forbidden = forbidden | name_is(part_now, k);
        end
        is_pseudo = part_now.name_cand[KW_COLON] && part_now.name_pos != 5'd0;

        // a value end completes the header; block end completes an open one
        finish = (item.part_end && item.in_value) || (item.message_end && part_now.pending);

        if (finish) begin
            any_w = 1'b1;
            if (first_error_reg == RSN_OK) begin
                if (part_now.name_upper) begin
                    chk = RSN_UPPER;
                end else if (is_pseudo) begin
                    if (pseudo_closed_reg) begin
                        chk = RSN_PSEUDO;
                    end else if (check_mode == MODE_REQUEST) begin
                        if (rq_hit == 4'b0000 || (rq_hit & pseudo_seen_reg[3:0]) != 4'b0000) begin
                            chk = RSN_PSEUDO;
                        end else begin
                            seen_w[3:0] = pseudo_seen_reg[3:0] | rq_hit;
                            if (rq_hit[KW_METHOD] && value_is(part_now, VW_CONNECT)) begin
                                connect_w = 1'b1;
                            end
                        end
                    end else begin
                        if (!name_is(part_now, KW_STATUS) || pseudo_seen_reg[KW_STATUS]) begin
                            chk = RSN_PSEUDO;
                        end else begin
                            seen_w[KW_STATUS] = 1'b1;
                            if (part_now.value_pos != 4'd3 || part_now.bad_digit) begin
                                chk = RSN_STATUS;
                            end else begin
                                status_w = part_now.digits;
                            end
                        end
                    end
                end else begin
                    closed_w = 1'b1;
                    if (forbidden) begin
                        chk = RSN_FORBID;
                    end else if (name_is(part_now, KW_TE) &&
                                 !value_is(part_now, VW_TRAILERS)) begin
                        chk = RSN_FORBID;
                    end
                end
                fe_w = chk;
            end
        end

        if (fe_w != RSN_OK) begin
            reason = fe_w;
        end else if (!any_w) begin
            reason = RSN_EMPTY;
        end else if (check_mode == MODE_REQUEST) begin
            if (connect_w) begin
                reason = (seen_w[KW_METHOD] && seen_w[KW_AUTH] && !seen_w[KW_SCHEME]
                          && !seen_w[KW_PATH]) ? RSN_OK : RSN_MISSING;
            end else begin
                reason = (seen_w[KW_METHOD] && seen_w[KW_SCHEME] && seen_w[KW_PATH])
                         ? RSN_OK : RSN_MISSING;
            end
        end else if (!seen_w[KW_STATUS]) begin
            reason = RSN_MISSING;
        end else if (status_w == STATUS_SWITCHING) begin
            reason = RSN_SWITCH;
        end else begin
            reason = RSN_OK;
        end

        result_valid         = item.message_end;
        result.block_valid   = (reason == RSN_OK);
        result.reject_reason = reason;
        result.status_value  = (check_mode == MODE_RESPONSE && seen_w[KW_STATUS])
                               ? status_w : 10'd0;
        part_clear           = finish || item.message_end;

        if (item.message_end) begin
            first_error_next   = RSN_OK;
            pseudo_seen_next   = '0;
            pseudo_closed_next = 1'b0;
            connect_next       = 1'b0;
            status_next        = '0;
            any_header_next    = 1'b0;
        end else begin
            first_error_next   = fe_w;
            pseudo_seen_next   = seen_w;
            pseudo_closed_next = closed_w;
            connect_next       = connect_w;
            status_next        = status_w;
            any_header_next    = any_w;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_error_reg   <= RSN_OK;
            pseudo_seen_reg   <= '0;
            pseudo_closed_reg <= 1'b0;
            connect_reg       <= 1'b0;
            status_reg        <= '0;
            any_header_reg    <= 1'b0;
        end else if (step_en) begin
            first_error_reg   <= first_error_next;
            pseudo_seen_reg   <= pseudo_seen_next;
            pseudo_closed_reg <= pseudo_closed_next;
            connect_reg       <= connect_next;
            status_reg        <= status_next;
            any_header_reg    <= any_header_next;
        end
    end

endmodule

FILE: design/http3_header_validator.sv
// HTTP/3 header block validator, top level.
// Depends on h3hv_pkg, h3hv_part_match and h3hv_rules.
//
// Usage:
//   s_axis carries the header block one byte per transaction: tdata is the
//   byte, tuser flags name/value, byte presence and end of the current part,
//   tlast closes the block. Each completed header is checked on the fly.
//   m_axis carries one verdict per block, in the transaction after tlast:
//   tuser is the pass flag, tdata the reject reason and parsed :status.
//   cfg_valid/cfg_data write check_mode (0 request rules, 1 response rules);
//   write it only while no block is in flight. cfg_ready is always high.
// Timing:
//   One byte per cycle sustained while the receiver takes verdicts. A byte is
//   held in the input register, is evaluated against the match state there,
//   and the verdict lands in the output register, which drives m_axis_tvalid.
//   The output register holds a verdict while the receiver stalls; the input
//   register stops advancing only then, so s_axis_tready drops at most behind
//   one buffered byte.
// Reset: aresetn (synchronous, active low) clears all match state, the mode
//   (request rules) and both registers' valid flags.
module http3_header_validator
    import h3hv_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [2:0]  s_axis_tuser,   // [0] in_value, [1] byte_present, [2] part_end
    input  logic        s_axis_tlast,   // message_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [2:0] reject_reason, [12:3] status_value, zero fill
    output logic        m_axis_tuser,   // [0] block_valid
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_data        // [0] check_mode
);

    logic    in_vld_reg, in_vld_next;
    item_t   in_item_reg;
    logic    out_vld_reg, out_vld_next;
    result_t out_res_reg;
    logic    check_mode_reg;

    logic    step_en;
    logic    s_accept;
    logic    part_clear;
    logic    res_valid;
    result_t res;
    part_t   part_now;

    assign cfg_ready     = 1'b1;
    assign step_en       = in_vld_reg && (!out_vld_reg || m_axis_tready);
    assign s_axis_tready = !in_vld_reg || step_en;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_accept) begin
            in_vld_next = 1'b1;
        end else if (step_en) begin
            in_vld_next = 1'b0;
        end
        out_vld_next = out_vld_reg;
        if (step_en && res_valid) begin
            out_vld_next = 1'b1;
        end else if (m_axis_tready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg     <= 1'b0;
            out_vld_reg    <= 1'b0;
            check_mode_reg <= MODE_REQUEST;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (cfg_valid) begin
                check_mode_reg <= cfg_data[0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg.data_byte    <= s_axis_tdata;
            in_item_reg.in_value     <= s_axis_tuser[0];
            in_item_reg.byte_present <= s_axis_tuser[1];
            in_item_reg.part_end     <= s_axis_tuser[2];
            in_item_reg.message_end  <= s_axis_tlast;
        end
        if (step_en && res_valid) begin
            out_res_reg <= res;
        end
    end

    h3hv_part_match u_match (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (step_en),
        .item       (in_item_reg),
        .part_clear (part_clear),
        .part_now   (part_now)
    );

    h3hv_rules u_rules (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_en      (step_en),
        .item         (in_item_reg),
        .part_now     (part_now),
        .check_mode   (check_mode_reg),
        .part_clear   (part_clear),
        .result_valid (res_valid),
        .result       (res)
    );

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tuser  = out_res_reg.block_valid;
    assign m_axis_tdata  = {3'b000, out_res_reg.status_value, out_res_reg.reject_reason};

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for http3_header_validator: directed header blocks, then random traffic.
// Depends on h3hv_pkg and the design files; compares every verdict against an in-bench header tracker.
module testbench;
    import h3hv_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;      // [7:0] data_byte
    logic [2:0]  s_axis_tuser = '0;      // [0] in_value, [1] byte_present, [2] part_end
    logic        s_axis_tlast = 1'b0;    // message_end
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;           // [2:0] reject_reason, [12:3] status_value
    logic        m_axis_tuser;           // [0] block_valid
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_data = '0;          // [0] check_mode

    http3_header_validator u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // ---------------- header tracker ----------------
    string name_kw [NAME_WORDS] = '{":method", ":scheme", ":path", ":authority", ":status", "te",
        "connection", "keep-alive", "proxy-connection", "transfer-encoding", "upgrade"};
    string value_kw [VALUE_WORDS] = '{"CONNECT", "trailers"};

    logic                   mode_now;
    logic [2:0]             err_first;
    logic [4:0]             nm_pos;
    logic [NAME_CAND_W-1:0] nm_cand;
    logic                   nm_upper;
    logic [3:0]             vl_pos;
    logic [VALUE_WORDS-1:0] vl_cand;
    logic [9:0]             vl_num;
    logic                   vl_nondigit;
    logic                   hdr_open;
    logic [4:0]             seen;
    logic                   section_closed;
    logic                   connect_seen;
    logic [9:0]             status_kept;
    logic                   got_header;

    result_t verdicts_due [$];
    int      mismatches = 0;
    int      items_sent = 0;
    logic    steady_flow = 1'b0;

    function automatic void clear_part();
        nm_pos      = '0;
        nm_cand     = '1;
        nm_upper    = 1'b0;
        vl_pos      = '0;
        vl_cand     = '1;
        vl_num      = '0;
        vl_nondigit = 1'b0;
        hdr_open    = 1'b0;
    endfunction

    function automatic void clear_block();
        clear_part();
        err_first      = RSN_OK;
        seen           = '0;
        section_closed = 1'b0;
        connect_seen   = 1'b0;
        status_kept    = '0;
        got_header     = 1'b0;
    endfunction

    function automatic void take_name_byte(input logic [7:0] b);
        logic [7:0] c;
        for (int k = 0; k < NAME_WORDS; k++) begin
            if (nm_pos >= name_kw[k].len()) begin
                nm_cand[k] = 1'b0;
            end else begin
                c = name_kw[k][nm_pos];
                if (c != b) nm_cand[k] = 1'b0;
            end
        end
        if (nm_pos == 0 && b != CH_COLON) nm_cand[KW_COLON] = 1'b0;
        if (b >= "A" && b <= "Z") nm_upper = 1'b1;
        if (nm_pos != 5'd31) nm_pos = nm_pos + 1'b1;
    endfunction

    function automatic void take_value_byte(input logic [7:0] b);
        logic [7:0] c;
        for (int k = 0; k < VALUE_WORDS; k++) begin
            if (vl_pos >= value_kw[k].len()) begin
                vl_cand[k] = 1'b0;
            end else begin
                c = value_kw[k][vl_pos];
                if (c != b) vl_cand[k] = 1'b0;
            end
        end
        // only the first three bytes feed the status number
        if (vl_pos < 3) begin
            if (b >= CH_ZERO && b <= "9") vl_num = 10'(vl_num * 10 + (b - CH_ZERO));
            else vl_nondigit = 1'b1;
        end
        if (vl_pos != 4'd15) vl_pos = vl_pos + 1'b1;
    endfunction

    function automatic logic name_hit(input int k);
        return nm_cand[k] && (nm_pos == name_kw[k].len());
    endfunction

    function automatic logic value_hit(input int k);
        return vl_cand[k] && (vl_pos == value_kw[k].len());
    endfunction

    function automatic logic [2:0] judge_header();
        if (nm_upper) return RSN_UPPER;
        if (nm_cand[KW_COLON] && nm_pos != 0) begin
            if (section_closed) return RSN_PSEUDO;
            if (mode_now == MODE_REQUEST) begin
                for (int k = KW_METHOD; k <= KW_AUTH; k++) begin
                    if (name_hit(k)) begin
                        if (seen[k]) return RSN_PSEUDO;
                        seen[k] = 1'b1;
                        if (k == KW_METHOD && value_hit(VW_CONNECT)) connect_seen = 1'b1;
                        return RSN_OK;
                    end
                end
                return RSN_PSEUDO;
            end
            if (!name_hit(KW_STATUS) || seen[KW_STATUS]) return RSN_PSEUDO;
            seen[KW_STATUS] = 1'b1;
            if (vl_pos != 3 || vl_nondigit) return RSN_STATUS;
            status_kept = vl_num;
            return RSN_OK;
        end
        // any regular field (an empty name too) closes the pseudo section
        section_closed = 1'b1;
        for (int k = KW_CONN; k < NAME_WORDS; k++) begin
            if (name_hit(k)) return RSN_FORBID;
        end
        if (name_hit(KW_TE) && !value_hit(VW_TRAILERS)) return RSN_FORBID;
        return RSN_OK;
    endfunction

    function automatic void close_header();
        got_header = 1'b1;
        if (err_first == RSN_OK) err_first = judge_header();
        clear_part();
    endfunction

    function automatic logic [2:0] block_reason();
        if (err_first != RSN_OK) return err_first;
        if (!got_header) return RSN_EMPTY;
        if (mode_now == MODE_REQUEST) begin
            if (connect_seen)
                return (seen[KW_METHOD] && seen[KW_AUTH] && !seen[KW_SCHEME] && !seen[KW_PATH])
                    ? RSN_OK : RSN_MISSING;
            return (seen[KW_METHOD] && seen[KW_SCHEME] && seen[KW_PATH]) ? RSN_OK : RSN_MISSING;
        end
        if (!seen[KW_STATUS]) return RSN_MISSING;
        if (status_kept == STATUS_SWITCHING) return RSN_SWITCH;
        return RSN_OK;
    endfunction

    function automatic void track_header_byte(input item_t it);
        result_t v;
        logic [2:0] why;
        if (it.byte_present) begin
            if (it.in_value) take_value_byte(it.data_byte);
            else take_name_byte(it.data_byte);
        end
        if (it.byte_present || it.part_end) hdr_open = 1'b1;
        if (it.part_end && it.in_value) close_header();
        if (it.message_end) begin
            if (hdr_open) close_header();
            why = block_reason();
            v.block_valid   = (why == RSN_OK);
            v.reject_reason = why;
            v.status_value  = (mode_now == MODE_RESPONSE && seen[KW_STATUS]) ? status_kept : '0;
            verdicts_due.push_back(v);
            clear_block();
        end
    endfunction

    // ---------------- monitor and checker ----------------
    always @(posedge aclk) begin
        result_t want;
        item_t   it;
        if (!aresetn) begin
            mode_now = MODE_REQUEST;
            clear_block();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (verdicts_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: verdict with none pending: expected nothing, %s",
                             $time, $sformatf("got valid=%0b reason=%0d status=%0d",
                             m_axis_tuser, m_axis_tdata[2:0], m_axis_tdata[12:3]));
                end else begin
                    want = verdicts_due.pop_front();
                    if (want.block_valid !== m_axis_tuser || want.reject_reason !== m_axis_tdata[2:0]
                            || want.status_value !== m_axis_tdata[12:3]) begin
                        mismatches++;
                        $display("%0t: verdict mismatch: expected valid=%0b reason=%0d status=%0d,",
                                 $time, want.block_valid, want.reject_reason, want.status_value,
                                 " got valid=%0b reason=%0d status=%0d",
                                 m_axis_tuser, m_axis_tdata[2:0], m_axis_tdata[12:3]);
                    end
                end
            end
            if (cfg_valid && cfg_ready) mode_now = cfg_data[0];
            if (s_axis_tvalid && s_axis_tready) begin
                it.data_byte    = s_axis_tdata;
                it.in_value     = s_axis_tuser[0];
                it.byte_present = s_axis_tuser[1];
                it.part_end     = s_axis_tuser[2];
                it.message_end  = s_axis_tlast;
                track_header_byte(it);
            end
        end
    end

    always @(negedge aclk) begin
        m_axis_tready = steady_flow || ($urandom_range(0, 99) >= 17);
    end

    // ---------------- stimulus helpers ----------------
    task automatic send_item(input logic [7:0] b, input logic iv, input logic bp,
                             input logic pe, input logic me);
        @(negedge aclk);
        while (!steady_flow && $urandom_range(0, 99) < 17) begin
            s_axis_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        s_axis_tuser  = {pe, bp, iv};
        s_axis_tlast  = me;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        items_sent++;
    endtask

    // name or value from a string; an empty part becomes a marker when it must close something
    task automatic send_part(input string s, input logic iv, input logic close, input logic last);
        int n;
        n = s.len();
        if (n == 0) begin
            if (close || last) send_item(8'($urandom_range(0, 255)), iv, 1'b0, close, last);
        end else begin
            for (int i = 0; i < n; i++)
                send_item(s[i], iv, 1'b1, close && i == n - 1, last && i == n - 1);
        end
    endtask

    task automatic send_header(input string nm, input string vl, input logic me);
        send_part(nm, 1'b0, 1'b0, 1'b0);
        send_part(vl, 1'b1, 1'b1, me);
    endtask

    task automatic send_end();
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, 1'b1);
    endtask

    task automatic request_base();
        send_header(":method", "GET", 1'b0);
        send_header(":scheme", "https", 1'b0);
        send_header(":path", "/", 1'b0);
    endtask

    // stop sending, let every pending verdict arrive plus the pipeline latency
    task automatic wait_verdicts();
        @(negedge aclk);
        s_axis_tvalid = 1'b0;
        while (verdicts_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_mode(input logic m);
        wait_verdicts();
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data  = m;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    function automatic string rand_text(input int n, input logic [7:0] lo, input logic [7:0] hi);
        string s;
        s = "";
        for (int i = 0; i < n; i++) begin
            s = {s, "."};
            s[i] = 8'($urandom_range(lo, hi));
        end
        return s;
    endfunction

    function automatic string pick_method();
        case ($urandom_range(0, 4))
            0: return "POST";
            1: return "CONNECT";
            2: return "connect";
            default: return "GET";
        endcase
    endfunction

    function automatic string pick_status();
        case ($urandom_range(0, 9))
            6: return "101";
            7: return rand_text($urandom_range(0, 5), "0", "9");
            8: return rand_text(3, 1, 255);
            9: return "200";
            default: return rand_text(3, "0", "9");
        endcase
    endfunction

    function automatic string pick_pseudo();
        case ($urandom_range(0, 7))
            0: return ":status";
            1: return ":method";
            2: return ":path";
            3: return ":scheme";
            4: return ":authority";
            5: return ":foo";
            6: return ":";
            default: return ":Path";
        endcase
    endfunction

    function automatic string pick_field();
        case ($urandom_range(0, 15))
            0: return "host";
            1: return "te";
            2: return "connection";
            3: return "keep-alive";
            4: return "proxy-connection";
            5: return "transfer-encoding";
            6: return "upgrade";
            7: return "accept";
            8: return "Accept";
            9: return "connectio";
            10: return "upgraded";
            11: return "t";
            12: return "";
            13: return rand_text($urandom_range(1, 40), "a", "z");
            default: return rand_text($urandom_range(1, 8), "a", "z");
        endcase
    endfunction

    function automatic string pick_value();
        case ($urandom_range(0, 9))
            0: return "trailers";
            1: return "trailer";
            2: return "trailersx";
            3: return "CONNECT";
            4: return "CONNEC";
            5: return "";
            6: return rand_text(3, "0", "9");
            default: return rand_text($urandom_range(1, 20), 32, 126);
        endcase
    endfunction

    // one header block, mostly well formed for the current mode
    task automatic random_block();
        string nm [$];
        string vl [$];
        string t;
        int    np, j, n, style;
        logic  connect, last;
        if (mode_now == MODE_REQUEST) begin
            connect = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 19) != 0) begin
                nm.push_back(":method");
                if (connect) vl.push_back("CONNECT");
                else vl.push_back(pick_method());
            end
            if ((!connect || $urandom_range(0, 4) == 0) && $urandom_range(0, 19) != 0) begin
                nm.push_back(":scheme");
                vl.push_back($urandom_range(0, 1) ? "https" : "http");
            end
            if ((!connect || $urandom_range(0, 4) == 0) && $urandom_range(0, 19) != 0) begin
                nm.push_back(":path");
                vl.push_back({"/", rand_text($urandom_range(0, 6), "a", "z")});
            end
            if (connect || $urandom_range(0, 1) == 0) begin
                nm.push_back(":authority");
                vl.push_back(rand_text($urandom_range(1, 10), "a", "z"));
            end
        end else if ($urandom_range(0, 19) != 0) begin
            nm.push_back(":status");
            vl.push_back(pick_status());
        end
        if ($urandom_range(0, 9) == 0) begin
            nm.push_back(pick_pseudo());
            vl.push_back(pick_value());
        end
        np = nm.size();
        for (int i = np - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = nm[i]; nm[i] = nm[j]; nm[j] = t;
            t = vl[i]; vl[i] = vl[j]; vl[j] = t;
        end
        repeat ($urandom_range(0, 3)) begin
            nm.push_back(pick_field());
            vl.push_back(pick_value());
        end
        if ($urandom_range(0, 19) == 0) begin
            nm.push_back(pick_pseudo());
            vl.push_back("x");
        end
        if ($urandom_range(0, 29) == 0) begin
            nm.delete();
            vl.delete();
        end
        // stray items ahead of the block
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 4))
                send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          $urandom_range(0, 7) == 0);
        end
        // 0: tlast on final value byte, 1: separate end marker,
        // 2: final value left open, 3: final header has only a name
        style = $urandom_range(0, 3);
        n = nm.size();
        for (int i = 0; i < n; i++) begin
            last = (i == n - 1);
            if (last && style == 3) begin
                send_part(nm[i], 1'b0, 1'b0, 1'b1);
            end else begin
                send_part(nm[i], 1'b0, $urandom_range(0, 3) == 0, 1'b0);
                send_part(vl[i], 1'b1, !(last && style == 2), last && style != 1);
            end
        end
        if (style == 1 || n == 0) send_end();
    endtask

    // ---------------- tests ----------------
    task automatic test_request_rules();
        write_mode(MODE_REQUEST);
        request_base();
        send_header("host", "a", 1'b1);
        send_end();
        send_header(":method", "CONNECT", 1'b0);
        send_header(":authority", "h:443", 1'b1);
        send_header(":method", "CONNECT", 1'b0);
        send_header(":authority", "h", 1'b0);
        send_header(":path", "/", 1'b1);
        send_header(":method", "GET", 1'b0);
        send_header(":scheme", "http", 1'b1);
    endtask

    task automatic test_pseudo_rules();
        request_base();
        send_header(":path", "/b", 1'b1);
        send_header(":method", "GET", 1'b0);
        send_header("host", "a", 1'b0);
        send_header(":scheme", "https", 1'b0);
        send_header(":path", "/", 1'b1);
        request_base();
        send_header(":foo", "x", 1'b1);
        request_base();
        send_header(":status", "200", 1'b1);
        request_base();
        send_header("Host", "a", 1'b1);
        // empty name counts as a regular field, so a later pseudo is late
        send_header("", "v", 1'b0);
        request_base();
        send_end();
    endtask

    task automatic test_forbidden_fields();
        request_base();
        send_header("connection", "close", 1'b1);
        request_base();
        send_header("keep-alive", "1", 1'b1);
        request_base();
        send_header("proxy-connection", "x", 1'b1);
        request_base();
        send_header("transfer-encoding", "chunked", 1'b1);
        request_base();
        send_header("upgrade", "h2c", 1'b1);
        request_base();
        send_header("te", "trailers", 1'b1);
        request_base();
        send_header("te", "gzip", 1'b1);
    endtask

    task automatic test_response_status();
        write_mode(MODE_RESPONSE);
        send_header(":status", "200", 1'b0);
        send_header("server", "x", 1'b1);
        send_header(":status", "101", 1'b1);
        send_header(":status", "20", 1'b1);
        send_header(":status", "2x0", 1'b1);
        send_header(":status", "2000", 1'b1);
        send_header(":status", "999", 1'b1);
        send_header(":status", "000", 1'b1);
        send_header("server", "x", 1'b1);
        send_header(":status", "200", 1'b0);
        send_header(":status", "204", 1'b1);
        send_header(":method", "GET", 1'b0);
        send_header(":status", "200", 1'b1);
        send_header("date", "x", 1'b0);
        send_header(":status", "200", 1'b1);
    endtask

    task automatic test_stream_corners();
        write_mode(MODE_REQUEST);
        // extreme byte values in name and value
        request_base();
        send_item(8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
        send_item(8'hFF, 1'b0, 1'b1, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b1, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b1, 1'b1, 1'b1);
        // name and value longer than the position counters
        request_base();
        send_header("x-very-long-header-name-that-keeps-going", "value-longer-than-fifteen", 1'b1);
        // block ends in the middle of a name
        request_base();
        send_part("x-a", 1'b0, 1'b0, 1'b1);
        // name bytes resumed after value bytes
        send_header(":method", "GET", 1'b0);
        send_header(":scheme", "https", 1'b0);
        send_part(":pa", 1'b0, 1'b1, 1'b0);
        send_part("q", 1'b1, 1'b0, 1'b0);
        send_part("th", 1'b0, 1'b0, 1'b0);
        send_part("/", 1'b1, 1'b1, 1'b1);
        // items after the first error, the later error must not replace it
        send_header("Bad", "x", 1'b0);
        send_header(":path", "/", 1'b0);
        send_header("connection", "x", 1'b0);
        send_header("host", "", 1'b1);
        // mode switch inside a block, pipeline drained first
        send_header(":method", "GET", 1'b0);
        write_mode(MODE_RESPONSE);
        send_header(":status", "200", 1'b1);
        write_mode(MODE_REQUEST);
    endtask

    task automatic test_random_traffic();
        int target;
        for (int round = 0; round < 4; round++) begin
            write_mode(round[0] ? MODE_RESPONSE : MODE_REQUEST);
            steady_flow = (round == 2);
            target = items_sent + 160;
            while (items_sent < target) random_block();
            wait_verdicts();
            steady_flow = 1'b0;
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_request_rules();
        test_pseudo_rules();
        test_forbidden_fields();
        test_response_status();
        test_stream_corners();
        test_random_traffic();
        wait_verdicts();
        if (mismatches == 0)
            $display("http3_header_validator verification clean");
        else
            $display("http3_header_validator verification failed");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("http3_header_validator verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
design/h3hv_pkg.sv
design/h3hv_part_match.sv
design/h3hv_rules.sv
design/http3_header_validator.sv
test/testbench.sv
